/* rtl/core/veif_pkg.sv */
`default_nettype none

package veif_pkg;

	localparam int POS_WIDTH = 24;
	localparam int VEL_WIDTH = 32;

	// 3p - 4p1 + p2 needs three more bits than a position
	localparam int DIFF_W  = POS_WIDTH + 3;
	localparam int MUL_A_W = (VEL_WIDTH > DIFF_W) ? VEL_WIDTH : DIFF_W;
	localparam int COEF_W  = 26;
	localparam int PROD_W  = MUL_A_W + COEF_W;
	// seven products summed
	localparam int ACC_W   = PROD_W + 3;

	localparam int RECIP_SHIFT = 24;
	localparam int COEF_SHIFT  = 22;

	localparam int NUM_AXES = 3;
	localparam int AXIS_W   = 2;
	localparam int TAP_W    = 3;

	typedef logic signed [COEF_W-1:0]    coef_t;
	typedef logic signed [MUL_A_W-1:0]   mul_a_t;
	typedef logic signed [PROD_W-1:0]    prod_t;
	typedef logic signed [ACC_W-1:0]     acc_t;
	typedef logic signed [POS_WIDTH-1:0] pos_t;
	typedef logic signed [VEL_WIDTH-1:0] vel_t;
	typedef logic signed [DIFF_W-1:0]    diff_t;

	localparam logic [1:0] UNITS_MM = 2'd0;
	localparam logic [1:0] UNITS_CM = 2'd1;
	localparam logic [1:0] UNITS_DM = 2'd2;
	localparam logic [1:0] UNITS_M  = 2'd3;

	// filter taps, in the order the sequencer walks them
	localparam logic [TAP_W-1:0] TAP_X  = 3'd0;
	localparam logic [TAP_W-1:0] TAP_X3 = 3'd1;
	localparam logic [TAP_W-1:0] TAP_X1 = 3'd2;
	localparam logic [TAP_W-1:0] TAP_X2 = 3'd3;
	localparam logic [TAP_W-1:0] TAP_Y1 = 3'd4;
	localparam logic [TAP_W-1:0] TAP_Y2 = 3'd5;
	localparam logic [TAP_W-1:0] TAP_Y3 = 3'd6;

	localparam coef_t VEL_GAIN = coef_t'(500);
	localparam coef_t COEF_B0  = coef_t'(921);
	localparam coef_t COEF_B1  = coef_t'(2763);
	localparam coef_t COEF_A1  = coef_t'(11529303);
	localparam coef_t COEF_A2N = coef_t'(-10604039);
	localparam coef_t COEF_A3  = coef_t'(3261491);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_POS,
		ST_SCALE,
		ST_MUL_GAIN,
		ST_SAT_X,
		ST_MAC,
		ST_ACC_LAST,
		ST_WRITE,
		ST_DONE
	} veif_state_t;

	typedef struct packed {
		logic acc_clr;
		logic acc_en;
	} veif_mac_ctrl_t;

	// Q1.24 reciprocals of 1, 10, 100, 1000
	function automatic coef_t recip_of(input logic [1:0] units);
		case (units)
			UNITS_MM: return coef_t'(16777216);
			UNITS_CM: return coef_t'(1677722);
			UNITS_DM: return coef_t'(167772);
			UNITS_M:  return coef_t'(16777);
			default:  return coef_t'(16777216);
		endcase
	endfunction

	function automatic coef_t tap_coef(input logic [TAP_W-1:0] tap);
		case (tap)
			TAP_X, TAP_X3:  return COEF_B0;
			TAP_X1, TAP_X2: return COEF_B1;
			TAP_Y1:         return COEF_A1;
			TAP_Y2:         return COEF_A2N;
			TAP_Y3:         return COEF_A3;
			default:        return coef_t'(0);
		endcase
	endfunction

	function automatic vel_t sat_vel(input acc_t v);
		acc_t hi;
		acc_t lo;
		hi = acc_t'({1'b0, {(VEL_WIDTH-1){1'b1}}});
		lo = -hi - acc_t'(1);
		if (v > hi)
			return {1'b0, {(VEL_WIDTH-1){1'b1}}};
		else if (v < lo)
			return {1'b1, {(VEL_WIDTH-1){1'b0}}};
		else
			return v[VEL_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/veif_mac.sv */
`default_nettype none

module veif_mac (
	input  wire logic                   clk,
	input  wire veif_pkg::veif_mac_ctrl_t ctrl,
	input  wire veif_pkg::mul_a_t       a,
	input  wire veif_pkg::coef_t        b,
	output veif_pkg::prod_t             prod_q,
	output veif_pkg::acc_t              acc_q
);
	import veif_pkg::*;

	// product is registered every cycle; the sequencer picks which one to keep
	always_ff @(posedge clk) begin
		prod_q <= prod_t'(a) * prod_t'(b);
		if (ctrl.acc_clr)
			acc_q <= '0;
		else if (ctrl.acc_en)
			acc_q <= acc_q + acc_t'(prod_q);
	end

endmodule

`default_nettype wire

/* rtl/core/velocity_estimate_iir_filter.sv */
// One word at a time: ready only while idle. Each axis of a word takes 13
// steps through the single shared multiply-accumulate unit (scale, gain,
// seven filter taps); it is idle again once the output word is free.
// Reset (arst_n low): histories cleared to zero, units_q to mm,
// output word empty, block idle and ready.
`default_nettype none

module velocity_estimate_iir_filter (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_wdata,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire veif_pkg::pos_t           pos_x,
	input  wire veif_pkg::pos_t           pos_y,
	input  wire veif_pkg::pos_t           pos_z,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output veif_pkg::pos_t                scaled_x,
	output veif_pkg::pos_t                scaled_y,
	output veif_pkg::pos_t                scaled_z,
	output veif_pkg::vel_t                vel_x,
	output veif_pkg::vel_t                vel_y,
	output veif_pkg::vel_t                vel_z
);
	import veif_pkg::*;

	veif_state_t state_q, state_nxt;
	logic [1:0]        units_q;
	logic [AXIS_W-1:0] axis_q;
	logic [TAP_W-1:0]  tap_q;
	logic              out_valid_q;

	// axis 0 of every rotating array is the axis being worked on
	pos_t pos_q    [NUM_AXES];
	pos_t ph0_q    [NUM_AXES];
	pos_t ph1_q    [NUM_AXES];
	vel_t xh_q     [NUM_AXES][3];
	vel_t yh_q     [NUM_AXES][3];
	pos_t sp_res_q [NUM_AXES];
	vel_t vel_res_q[NUM_AXES];
	pos_t sp_q;
	vel_t x_q;

	veif_mac_ctrl_t mac_ctrl;
	mul_a_t         mul_a;
	coef_t          mul_b;
	prod_t          prod_q;
	acc_t           acc_q;

	logic  in_acc, ld_sp, ld_x, wr_axis, ld_out, last_axis, last_tap, out_free;
	prod_t pos_rnd;
	pos_t  sp_nxt;
	diff_t diff;
	vel_t  x_nxt, y_nxt, tap_val;
	acc_t  acc_rnd;

	veif_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q),
		.acc_q  (acc_q)
	);

	assign in_acc    = in_valid && in_ready;
	assign last_axis = (axis_q == AXIS_W'(NUM_AXES - 1));
	assign last_tap  = (tap_q == TAP_Y3);
	assign out_free  = !out_valid_q || out_ready;

	// round half up, then floor shift
	assign pos_rnd = prod_q + (prod_t'(1) <<< (RECIP_SHIFT - 1));
	assign sp_nxt  = pos_t'(pos_rnd >>> RECIP_SHIFT);
	assign diff    = (diff_t'(sp_q) <<< 1) + diff_t'(sp_q)
	               - (diff_t'(ph0_q[0]) <<< 2) + diff_t'(ph1_q[0]);
	assign x_nxt   = sat_vel(acc_t'(prod_q));
	assign acc_rnd = acc_q + (acc_t'(1) <<< (COEF_SHIFT - 1));
	assign y_nxt   = sat_vel(acc_rnd >>> COEF_SHIFT);

	always_comb begin
		case (tap_q)
			TAP_X:   tap_val = x_q;
			TAP_X3:  tap_val = xh_q[0][2];
			TAP_X1:  tap_val = xh_q[0][0];
			TAP_X2:  tap_val = xh_q[0][1];
			TAP_Y1:  tap_val = yh_q[0][0];
			TAP_Y2:  tap_val = yh_q[0][1];
			TAP_Y3:  tap_val = yh_q[0][2];
			default: tap_val = '0;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_nxt = ST_MUL_POS;
			ST_MUL_POS:  state_nxt = ST_SCALE;
			ST_SCALE:    state_nxt = ST_MUL_GAIN;
			ST_MUL_GAIN: state_nxt = ST_SAT_X;
			ST_SAT_X:    state_nxt = ST_MAC;
			ST_MAC:      if (last_tap) state_nxt = ST_ACC_LAST;
			ST_ACC_LAST: state_nxt = ST_WRITE;
			ST_WRITE:    state_nxt = last_axis ? ST_DONE : ST_MUL_POS;
			ST_DONE:     if (out_free) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready         = 1'b0;
		ld_sp            = 1'b0;
		ld_x             = 1'b0;
		wr_axis          = 1'b0;
		ld_out           = 1'b0;
		mac_ctrl.acc_clr = 1'b0;
		mac_ctrl.acc_en  = 1'b0;
		mul_a            = '0;
		mul_b            = '0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_MUL_POS: begin
				mul_a = mul_a_t'(pos_q[0]);
				mul_b = recip_of(units_q);
			end
			ST_SCALE: ld_sp = 1'b1;
			ST_MUL_GAIN: begin
				mul_a = mul_a_t'(diff);
				mul_b = VEL_GAIN;
			end
			ST_SAT_X: begin
				ld_x             = 1'b1;
				mac_ctrl.acc_clr = 1'b1;
			end
			ST_MAC: begin
				mul_a           = mul_a_t'(tap_val);
				mul_b           = tap_coef(tap_q);
				// product of the previous tap lands now
				mac_ctrl.acc_en = (tap_q != TAP_X);
			end
			ST_ACC_LAST: mac_ctrl.acc_en = 1'b1;
			ST_WRITE: wr_axis = 1'b1;
			ST_DONE: ld_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			units_q     <= UNITS_MM;
			axis_q      <= '0;
			tap_q       <= TAP_X;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				ph0_q[i] <= '0;
				ph1_q[i] <= '0;
				for (int j = 0; j < 3; j++) begin
					xh_q[i][j] <= '0;
					yh_q[i][j] <= '0;
				end
			end
		end else begin
			state_q <= state_nxt;
			if (cfg_we)
				units_q <= cfg_wdata;
			if (in_acc)
				axis_q <= '0;
			else if (wr_axis)
				axis_q <= axis_q + AXIS_W'(1);
			if (state_q == ST_MAC)
				tap_q <= last_tap ? TAP_X : tap_q + TAP_W'(1);
			if (ld_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (wr_axis) begin
				for (int i = 0; i < NUM_AXES - 1; i++) begin
					ph0_q[i] <= ph0_q[i+1];
					ph1_q[i] <= ph1_q[i+1];
					for (int j = 0; j < 3; j++) begin
						xh_q[i][j] <= xh_q[i+1][j];
						yh_q[i][j] <= yh_q[i+1][j];
					end
				end
				ph0_q[NUM_AXES-1]   <= sp_q;
				ph1_q[NUM_AXES-1]   <= ph0_q[0];
				xh_q[NUM_AXES-1][0] <= x_q;
				xh_q[NUM_AXES-1][1] <= xh_q[0][0];
				xh_q[NUM_AXES-1][2] <= xh_q[0][1];
				yh_q[NUM_AXES-1][0] <= y_nxt;
				yh_q[NUM_AXES-1][1] <= yh_q[0][0];
				yh_q[NUM_AXES-1][2] <= yh_q[0][1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
		end else if (wr_axis) begin
			for (int i = 0; i < NUM_AXES - 1; i++)
				pos_q[i] <= pos_q[i+1];
		end
		if (ld_sp)
			sp_q <= sp_nxt;
		if (ld_x)
			x_q <= x_nxt;
		if (wr_axis) begin
			for (int i = 0; i < NUM_AXES - 1; i++) begin
				sp_res_q[i]  <= sp_res_q[i+1];
				vel_res_q[i] <= vel_res_q[i+1];
			end
			sp_res_q[NUM_AXES-1]  <= sp_q;
			vel_res_q[NUM_AXES-1] <= y_nxt;
		end
		if (ld_out) begin
			scaled_x <= sp_res_q[0];
			scaled_y <= sp_res_q[1];
			scaled_z <= sp_res_q[2];
			vel_x    <= vel_res_q[0];
			vel_y    <= vel_res_q[1];
			vel_z    <= vel_res_q[2];
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/veif_checker.sv */
`default_nettype none

module veif_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire veif_pkg::pos_t scaled_x,
	input wire veif_pkg::vel_t vel_x
);
	import veif_pkg::*;

	// one word in flight: busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an input word was taken");

	// a word can never finish in the cycle after it was taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// idle block stays idle until a word shows up
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("ready dropped with no input word");

	a_out_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scaled_x) && $stable(vel_x))
		else $error("output word changed while stalled");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind velocity_estimate_iir_filter veif_checker u_veif_checker (.*);

`default_nettype wire
